// ----- rtl/dwmf_pkg.sv -----
// shared types and constants for the distinct window marker finder
package dwmf_pkg;

  localparam int MaxWindow = 16;
  localparam int MaxLine   = 4096;

  localparam int LetterW = 5;
  localparam int WsizeW  = 5;
  localparam int PosW    = 13;

  localparam logic [WsizeW-1:0] WsizeReset = WsizeW'(4);
  localparam logic [WsizeW-1:0] WsizeMin   = WsizeW'(2);
  localparam logic [WsizeW-1:0] WsizeMax   = WsizeW'(MaxWindow);
  localparam logic [PosW-1:0]   PosLimit   = PosW'(MaxLine);

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [WsizeW-1:0]  wsize_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef letter_t            window_t [MaxWindow];

endpackage

// ----- rtl/dwmf_distinct.sv -----
// pairwise compare of the newest window entries against each other
module dwmf_distinct
  import dwmf_pkg::*;
(
  input  window_t win,
  input  wsize_t  wsize,
  output logic    distinct
);

  always_comb begin
    distinct = 1'b1;
    for (int i = 0; i < MaxWindow; i++) begin
      for (int j = i + 1; j < MaxWindow; j++) begin
        // only pairs inside the active window count
        if ((WsizeW'(j) < wsize) && (win[i] == win[j])) begin
          distinct = 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/distinct_window_marker_finder.sv -----
// top level: sliding window all-distinct marker finder with output skid stage
// Takes one letter per cycle while in_stall is low, and reports via the output register the
// 1-based position of the first window of window_size letters that are all different; the
// whole update (window shift, count and the 16-entry pairwise compare) is done in the cycle
// the item is accepted, and a second output register lets the next item in while a result
// is still waiting. in_stall rises only when both output registers hold results. The window
// size is clamped to 2..16, and letters past position 4096 of a stream give no result.
module distinct_window_marker_finder
  import dwmf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  letter_t       in_letter,
  input  logic          in_start_of_stream,
  output logic          out_valid,
  input  logic          out_stall,
  output pos_t          out_marker_position,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  wsize_t        cfg_window_size
);

  wsize_t  wsize_r;
  window_t win_r, win_nxt, win_base;
  pos_t    seen_r, seen_nxt, seen_base;
  logic    found_r, found_nxt, found_base;

  logic    out_valid_r, skid_valid_r;
  pos_t    out_pos_r, skid_pos_r;

  wsize_t  wsize_eff;
  logic    accept, out_take, distinct, hit, res_valid;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  assign out_valid           = out_valid_r;
  assign out_marker_position = out_pos_r;

  always_comb begin
    wsize_eff = wsize_r;
    if (wsize_r < WsizeMin) begin
      wsize_eff = WsizeMin;
    end else if (wsize_r > WsizeMax) begin
      wsize_eff = WsizeMax;
    end
  end

  // a new stream starts from a cleared window and count
  always_comb begin
    for (int k = 0; k < MaxWindow; k++) begin
      win_base[k] = in_start_of_stream ? '0 : win_r[k];
    end
    seen_base  = in_start_of_stream ? '0 : seen_r;
    found_base = in_start_of_stream ? 1'b0 : found_r;

    win_nxt   = win_base;
    seen_nxt  = seen_base;
    found_nxt = found_base;
    if (seen_base < PosLimit) begin
      win_nxt[0] = in_letter;
      for (int k = 1; k < MaxWindow; k++) begin
        win_nxt[k] = win_base[k-1];
      end
      seen_nxt = seen_base + PosW'(1);
    end
  end

  dwmf_distinct u_distinct (
    .win      (win_nxt),
    .wsize    (wsize_eff),
    .distinct (distinct)
  );

  assign hit = (seen_base < PosLimit) && !found_base &&
               (seen_nxt >= PosW'(wsize_eff)) && distinct;
  assign res_valid = accept && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= WsizeReset;
    end else if (cfg_valid && cfg_ready) begin
      wsize_r <= cfg_window_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      found_r <= 1'b0;
    end else if (accept) begin
      seen_r  <= seen_nxt;
      found_r <= found_nxt || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_pos_r <= skid_valid_r ? skid_pos_r : seen_nxt;
    end else if (res_valid) begin
      skid_pos_r <= seen_nxt;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item while the output register is empty");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pos_r != '0) && (out_pos_r <= PosLimit))
    else $error("result position out of range");

  a_one_per_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && found_r && !in_start_of_stream) |-> !hit)
    else $error("second marker in one stream");

  a_window_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (seen_nxt >= PosW'(wsize_eff)))
    else $error("marker reported before the window filled");

endmodule

// ----- tb/tb.sv -----
// testbench for the distinct window marker finder: random streams, self-checking
`timescale 1ns / 1ps

module tb;
  import dwmf_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int LongHold  = 200;

  typedef struct {
    letter_t letter;
    logic    restart;
  } letter_item_t;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid = 1'b0;
  logic    in_stall;
  letter_t in_letter = '0;
  logic    in_start_of_stream = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  pos_t    out_marker_position;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  wsize_t  cfg_window_size = '0;

  distinct_window_marker_finder u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_letter           (in_letter),
    .in_start_of_stream  (in_start_of_stream),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_marker_position (out_marker_position),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_window_size     (cfg_window_size)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // letters waiting to be sent, and marker positions waiting to come out
  letter_item_t letter_q[$];
  pos_t         marker_q[$];
  int           letters_queued = 0;
  int           letters_taken  = 0;

  // mirror of the block state
  letter_t recent[MaxWindow];
  int      seen_cnt;
  bit      marker_done;
  wsize_t  win_cfg;

  int   mismatches   = 0;
  int   markers_seen = 0;
  int   idle_cycles  = 0;
  pos_t want_pos;

  function automatic int active_window(input wsize_t v);
    if (v < WsizeMin) return int'(WsizeMin);
    if (v > WsizeMax) return int'(WsizeMax);
    return int'(v);
  endfunction

  task automatic track_letter(input letter_t code, input logic restart);
    int  w;
    bit  all_diff;
    w = active_window(win_cfg);
    if (restart) begin
      foreach (recent[k]) recent[k] = '0;
      seen_cnt    = 0;
      marker_done = 1'b0;
    end
    if (seen_cnt < MaxLine) begin
      for (int k = MaxWindow - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = code;
      seen_cnt++;
      if (!marker_done && seen_cnt >= w) begin
        all_diff = 1'b1;
        for (int i = 0; i < w; i++)
          for (int j = i + 1; j < w; j++)
            if (recent[i] == recent[j]) all_diff = 1'b0;
        if (all_diff) begin
          marker_done = 1'b1;
          marker_q.push_back(pos_t'(seen_cnt));
        end
      end
    end
  endtask

  task automatic push_item(input letter_t code, input logic restart);
    letter_q.push_back('{code, restart});
    letters_queued++;
  endtask

  // mostly streams that hit a marker at a random depth, some plain noise
  task automatic push_streams(input int budget);
    int      sent;
    int      w;
    int      plen;
    int      tlen;
    int      alpha;
    int      base;
    int      j;
    letter_t pool[32];
    letter_t tmp;
    sent = 0;
    while (sent < budget) begin
      w = active_window(win_cfg);
      if ($urandom_range(0, 3) != 0) begin
        plen  = $urandom_range(0, 20);
        alpha = $urandom_range(1, w - 1);
        base  = $urandom_range(0, 31);
        for (int k = 0; k < 32; k++) pool[k] = letter_t'(k);
        for (int k = 31; k > 0; k--) begin
          j       = $urandom_range(0, k);
          tmp     = pool[k];
          pool[k] = pool[j];
          pool[j] = tmp;
        end
        for (int n = 0; n < plen; n++)
          push_item(letter_t'(base + $urandom_range(0, alpha - 1)), n == 0);
        for (int n = 0; n < w; n++) push_item(pool[n], plen == 0 && n == 0);
        tlen = $urandom_range(0, 10);
        for (int n = 0; n < tlen; n++)
          push_item(letter_t'($urandom_range(0, 31)), $urandom_range(0, 15) == 0);
        sent += plen + w + tlen;
      end else begin
        tlen  = $urandom_range(1, 30);
        alpha = $urandom_range(1, 32);
        base  = $urandom_range(0, 31);
        for (int n = 0; n < tlen; n++)
          push_item(letter_t'(base + $urandom_range(0, alpha - 1)),
                    n == 0 || $urandom_range(0, 15) == 0);
        sent += tlen;
      end
    end
  endtask

  // every letter taken, every marker out, and the pipeline given time to settle
  task automatic wait_drained();
    while (letters_taken != letters_queued || marker_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window_size(input wsize_t v);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_window_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_cfg = v;
  endtask

  // sender: bursts of random length with random gaps
  int           burst_left = 0;
  int           gap_left   = 0;
  letter_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      foreach (recent[k]) recent[k] = '0;
      seen_cnt    = 0;
      marker_done = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_letter(in_letter, in_start_of_stream);
        letters_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (letter_q.size() > 0) begin
          next_item          = letter_q.pop_front();
          in_valid           <= 1'b1;
          in_letter          <= next_item.letter;
          in_start_of_stream <= next_item.restart;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks markers, stalls on its own pattern with two long hold-offs
  int stall_mode   = 0;
  int mode_cycles  = 0;
  int hold_left    = 0;
  int holds_done   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        markers_seen++;
        if (marker_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected marker_position %0d, none expected", out_marker_position);
        end else begin
          want_pos = marker_q.pop_front();
          if (out_marker_position !== want_pos) begin
            mismatches++;
            if (mismatches <= 10)
              $display("marker_position mismatch: expected %0d got %0d",
                       want_pos, out_marker_position);
          end
        end
      end
      // hold off only while plenty of letters are still queued, so the block fills up
      if (hold_left == 0 && holds_done < 2 && markers_seen >= 10 + 90 * holds_done &&
          letter_q.size() >= 60) begin
        hold_left = LongHold;
        holds_done++;
      end
      if (mode_cycles == 0) begin
        stall_mode  = $urandom_range(0, 2);
        mode_cycles = 48;
      end else begin
        mode_cycles--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("distinct_window_marker_finder verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n   = 1'b0;
    win_cfg = WsizeReset;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset window size: first check lands on the first full window
    for (int i = 0; i < 4; i++) push_item(letter_t'(i), i == 0);
    push_item(letter_t'(4), 1'b0);
    push_item(letter_t'(0), 1'b1);
    for (int i = 0; i < 4; i++) push_item(letter_t'(i), 1'b0);
    for (int i = 26; i < 30; i++) push_item(letter_t'(i), i == 26);
    push_item(letter_t'(31), 1'b1);
    push_item(letter_t'(30), 1'b0);
    push_item(letter_t'(31), 1'b0);
    push_item(letter_t'(30), 1'b0);
    push_streams(100);
    wait_drained();

    // smallest window
    write_window_size(wsize_t'(2));
    push_item(letter_t'(0), 1'b1);
    push_item(letter_t'(0), 1'b0);
    push_item(letter_t'(1), 1'b0);
    push_item(letter_t'(2), 1'b0);
    push_item(letter_t'(0), 1'b1);
    push_item(letter_t'(1), 1'b0);
    push_streams(100);
    wait_drained();

    // largest window, all 32 codes
    write_window_size(wsize_t'(16));
    for (int i = 0; i < 16; i++) push_item(letter_t'(i), i == 0);
    for (int i = 16; i < 32; i++) push_item(letter_t'(i), i == 16);
    push_streams(100);
    wait_drained();

    // out of range sizes clamp to the limits
    write_window_size(wsize_t'(0));
    push_item(letter_t'(0), 1'b1);
    push_item(letter_t'(0), 1'b0);
    push_item(letter_t'(1), 1'b0);
    push_streams(90);
    wait_drained();

    write_window_size(wsize_t'(31));
    push_streams(90);
    wait_drained();

    write_window_size(wsize_t'(1));
    push_streams(90);
    wait_drained();

    write_window_size(wsize_t'(17));
    push_streams(90);
    wait_drained();

    write_window_size(wsize_t'(14));
    push_streams(120);
    wait_drained();

    write_window_size(wsize_t'($urandom_range(0, 31)));
    push_streams(120);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && marker_q.size() == 0)
      $display("distinct_window_marker_finder verification clean");
    else
      $display("distinct_window_marker_finder verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dwmf_pkg.sv
rtl/dwmf_distinct.sv
rtl/distinct_window_marker_finder.sv
tb/tb.sv
